[hw/rtl/obb_pkg.sv]
// Package with payload types, stage count and the pipeline control struct.
`timescale 1ns / 1ps
package obb_pkg;

   // Number of register stages from input to result register
   localparam int StageCount = 6;

   typedef struct packed {
      logic signed [31:0] a_center_x;
      logic signed [31:0] a_center_y;
      logic signed [15:0] a_cos;
      logic signed [15:0] a_sin;
      logic [30:0]        a_half_len;
      logic [30:0]        a_half_wid;
      logic signed [31:0] b_center_x;
      logic signed [31:0] b_center_y;
      logic signed [15:0] b_cos;
      logic signed [15:0] b_sin;
      logic [30:0]        b_half_len;
      logic [30:0]        b_half_wid;
   } req_payload_type;

   typedef struct packed {
      logic overlap;
   } rsp_payload_type;

   // Per-stage load enables from the pipeline control
   typedef struct packed {
      logic [StageCount-1:0] load;
   } obb_ctl_type;

endpackage

[hw/rtl/obb_chan_if.sv]
// Valid/ready channel interface carrying one payload per beat.
`timescale 1ns / 1ps
interface obb_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/obb_ctl.sv]
// Pipeline control: per-stage valid bits and load enables with stall backflow.
`timescale 1ns / 1ps
module obb_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output obb_pkg::obb_ctl_type ctl
);
   import obb_pkg::*;

   logic [StageCount-1:0] valid_ff;
   logic [StageCount-1:0] valid_in;
   logic [StageCount:0]   load;

   // A stage loads when it is empty or its content moves on
   always_comb begin
      load[StageCount] = out_ready;
      for (int k = StageCount - 1; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k + 1];
      end
   end

   // Advance valid bits along with the data
   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < StageCount; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load  = load[StageCount-1:0];
   assign in_ready  = load[0];
   assign out_valid = valid_ff[StageCount-1];

   // A ready receiver lets the whole pipeline move
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      out_ready |-> in_ready)
      else $error("input stalled while output is ready");

   // A full, stalled pipeline takes no beat
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !out_ready) |-> !in_ready)
      else $error("beat accepted into a full stalled pipeline");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("stage valid set after reset");

endmodule

[hw/rtl/obb_dp.sv]
// Datapath: dot products, radius terms, center projections and the axis compare.
`timescale 1ns / 1ps
module obb_dp (
   input  logic                     clock,
   input  obb_pkg::obb_ctl_type     ctl,
   input  obb_pkg::req_payload_type in_data,
   output obb_pkg::rsp_payload_type out_data
);
   import obb_pkg::*;

   // Stage 0: center deltas and axis cross products
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [15:0] ac_ff, as_ff, bc_ff, bs_ff;
   logic signed [31:0] acbc_ff, asbs_ff, asbc_ff, acbs_ff;
   logic signed [31:0] acac_ff, asas_ff, bcbc_ff, bsbs_ff;
   logic [30:0]        ahl0_ff, ahw0_ff, bhl0_ff, bhw0_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         dx_ff   <= {in_data.b_center_x[31], in_data.b_center_x}
                  - {in_data.a_center_x[31], in_data.a_center_x};
         dy_ff   <= {in_data.b_center_y[31], in_data.b_center_y}
                  - {in_data.a_center_y[31], in_data.a_center_y};
         ac_ff   <= in_data.a_cos;
         as_ff   <= in_data.a_sin;
         bc_ff   <= in_data.b_cos;
         bs_ff   <= in_data.b_sin;
         acbc_ff <= in_data.a_cos * in_data.b_cos;
         asbs_ff <= in_data.a_sin * in_data.b_sin;
         asbc_ff <= in_data.a_sin * in_data.b_cos;
         acbs_ff <= in_data.a_cos * in_data.b_sin;
         acac_ff <= in_data.a_cos * in_data.a_cos;
         asas_ff <= in_data.a_sin * in_data.a_sin;
         bcbc_ff <= in_data.b_cos * in_data.b_cos;
         bsbs_ff <= in_data.b_sin * in_data.b_sin;
         ahl0_ff <= in_data.a_half_len;
         ahw0_ff <= in_data.a_half_wid;
         bhl0_ff <= in_data.b_half_len;
         bhw0_ff <= in_data.b_half_wid;
      end
   end

   // Stage 1: axis dot magnitudes and center projection products
   logic signed [32:0] p_sum, q_sum, na_sum, nb_sum;
   logic [31:0]        p_ff, q_ff, na_ff, nb_ff;
   logic signed [48:0] dxac_ff, dyas_ff, dxas_ff, dyac_ff;
   logic signed [48:0] dxbc_ff, dybs_ff, dxbs_ff, dybc_ff;
   logic [30:0]        ahl1_ff, ahw1_ff, bhl1_ff, bhw1_ff;

   always_comb begin
      p_sum  = 33'(acbc_ff) + 33'(asbs_ff);
      q_sum  = 33'(asbc_ff) - 33'(acbs_ff);
      na_sum = 33'(acac_ff) + 33'(asas_ff);
      nb_sum = 33'(bcbc_ff) + 33'(bsbs_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         p_ff    <= p_sum[32] ? 32'(-p_sum) : p_sum[31:0];
         q_ff    <= q_sum[32] ? 32'(-q_sum) : q_sum[31:0];
         na_ff   <= na_sum[31:0];
         nb_ff   <= nb_sum[31:0];
         dxac_ff <= dx_ff * ac_ff;
         dyas_ff <= dy_ff * as_ff;
         dxas_ff <= dx_ff * as_ff;
         dyac_ff <= dy_ff * ac_ff;
         dxbc_ff <= dx_ff * bc_ff;
         dybs_ff <= dy_ff * bs_ff;
         dxbs_ff <= dx_ff * bs_ff;
         dybc_ff <= dy_ff * bc_ff;
         ahl1_ff <= ahl0_ff;
         ahw1_ff <= ahw0_ff;
         bhl1_ff <= bhl0_ff;
         bhw1_ff <= bhw0_ff;
      end
   end

   // Stage 2: radius terms per axis and center distance magnitudes
   logic signed [49:0] d_sum [4];
   logic [62:0]        t_ff [4][3];
   logic [48:0]        dist2_ff [4];

   always_comb begin
      d_sum[0] = 50'(dxac_ff) + 50'(dyas_ff);
      d_sum[1] = 50'(dyac_ff) - 50'(dxas_ff);
      d_sum[2] = 50'(dxbc_ff) + 50'(dybs_ff);
      d_sum[3] = 50'(dybc_ff) - 50'(dxbs_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         t_ff[0][0] <= na_ff * ahl1_ff;
         t_ff[0][1] <= p_ff * bhl1_ff;
         t_ff[0][2] <= q_ff * bhw1_ff;
         t_ff[1][0] <= na_ff * ahw1_ff;
         t_ff[1][1] <= q_ff * bhl1_ff;
         t_ff[1][2] <= p_ff * bhw1_ff;
         t_ff[2][0] <= p_ff * ahl1_ff;
         t_ff[2][1] <= q_ff * ahw1_ff;
         t_ff[2][2] <= nb_ff * bhl1_ff;
         t_ff[3][0] <= q_ff * ahl1_ff;
         t_ff[3][1] <= p_ff * ahw1_ff;
         t_ff[3][2] <= nb_ff * bhw1_ff;
         for (int k = 0; k < 4; k++) begin
            dist2_ff[k] <= d_sum[k][49] ? 49'(-d_sum[k]) : d_sum[k][48:0];
         end
      end
   end

   // Stage 3: first partial radius sum
   logic [63:0] part_ff [4];
   logic [62:0] t3_ff [4];
   logic [48:0] dist3_ff [4];

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         for (int k = 0; k < 4; k++) begin
            part_ff[k]  <= 64'(t_ff[k][0]) + 64'(t_ff[k][1]);
            t3_ff[k]    <= t_ff[k][2];
            dist3_ff[k] <= dist2_ff[k];
         end
      end
   end

   // Stage 4: full radius sum
   logic [63:0] radii_ff [4];
   logic [48:0] dist4_ff [4];

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         for (int k = 0; k < 4; k++) begin
            radii_ff[k] <= part_ff[k] + 64'(t3_ff[k]);
            dist4_ff[k] <= dist3_ff[k];
         end
      end
   end

   // Stage 5: compare scaled distance with radii on every axis
   logic [3:0] sep;
   logic       overlap_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sep[k] = {1'b0, dist4_ff[k], 14'b0} > radii_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         overlap_ff <= ~|sep;
      end
   end

   assign out_data.overlap = overlap_ff;

endmodule

[hw/rtl/obb2d_overlap_test_top.sv]
// Top level of the two-box oriented separating-axis overlap test.
//
// Usage: a beat on req_ch carries two oriented boxes (center, main axis
// cos/sin in Q2.14, half extents in unsigned Q15.16). For each pair one beat
// comes back on rsp_ch with overlap = 1 when none of the four box axes
// separates them. Touching boxes count as overlapping.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// The result passes six register stages, the first loaded at the edge that
// takes the input beat: deltas, dot products, radius terms, two adds and the
// compare feeding the result register.
// Throughput: one box pair per cycle while the receiver takes results, set
// by the six-stage pipeline whose stages each hold one pair.
// Reset clears every stage valid bit; no result is pending afterwards.
// When the receiver stalls, the result register holds its beat and empty
// stages behind it still fill, so req_ch stays ready until the pipeline is
// full.
`timescale 1ns / 1ps
module obb2d_overlap_test_top (
   input logic      clock,
   input logic      reset,
   obb_chan_if.sink   req_ch,
   obb_chan_if.source rsp_ch
);
   import obb_pkg::*;

   obb_ctl_type ctl;

   obb_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .ctl       (ctl)
   );

   obb_dp u_dp (
      .clock    (clock),
      .ctl      (ctl),
      .in_data  (req_ch.payload),
      .out_data (rsp_ch.payload)
   );

endmodule

[tb/tb.sv]
// Testbench for the oriented-box separating-axis overlap test: random and directed box pairs.
`timescale 1ns / 1ps
module tb;
   import obb_pkg::*;

   // Expected overlap flags in order of acceptance, checked against result beats
   class overlap_scoreboard;
      bit expected_flags[$];
      int error_count;

      // Absolute value of a signed 64-bit product sum, as unsigned
      static function logic [63:0] magnitude(logic signed [63:0] v);
         return v < 0 ? -v : v;
      endfunction

      // Separating-axis test over the four box axes at exact width
      static function bit predict_overlap(req_payload_type p);
         logic signed [63:0] ax[4][2];
         logic signed [63:0] dx, dy;
         logic [63:0] half[4];
         logic [63:0] radii, distance;
         bit hit;
         dx = 64'(p.b_center_x) - 64'(p.a_center_x);
         dy = 64'(p.b_center_y) - 64'(p.a_center_y);
         ax[0][0] = 64'(p.a_cos);  ax[0][1] = 64'(p.a_sin);
         ax[1][0] = -64'(p.a_sin); ax[1][1] = 64'(p.a_cos);
         ax[2][0] = 64'(p.b_cos);  ax[2][1] = 64'(p.b_sin);
         ax[3][0] = -64'(p.b_sin); ax[3][1] = 64'(p.b_cos);
         half[0] = {33'd0, p.a_half_len}; half[1] = {33'd0, p.a_half_wid};
         half[2] = {33'd0, p.b_half_len}; half[3] = {33'd0, p.b_half_wid};
         hit = 1'b1;
         for (int i = 0; i < 4; i++) begin
            radii = '0;
            for (int j = 0; j < 4; j++)
               radii += magnitude(ax[i][0] * ax[j][0] + ax[i][1] * ax[j][1]) * half[j];
            distance = magnitude(dx * ax[i][0] + dy * ax[i][1]) << 14;
            if (distance > radii) hit = 1'b0;
         end
         return hit;
      endfunction

      function void note_request(req_payload_type p);
         expected_flags.push_back(predict_overlap(p));
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         error_count++;
      endtask

      task check_result(rsp_payload_type r);
         bit want;
         if (expected_flags.size() == 0) begin
            report_mismatch("result beat with nothing expected");
            return;
         end
         want = expected_flags.pop_front();
         if (r.overlap !== want)
            report_mismatch($sformatf("overlap got %0b want %0b", r.overlap, want));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   obb_chan_if #(.payload_type(req_payload_type)) req_ch();
   obb_chan_if #(.payload_type(rsp_payload_type)) rsp_ch();
   overlap_scoreboard board = new();

   int send_idle_pct, recv_idle_pct;
   bit hold_off;
   int idle_cycles;

   obb2d_overlap_test_top u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample both handshakes at the edge and feed the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.note_request(req_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.payload);
      end
   end

   // Drive ready: random stalls, or hold off for a long stretch
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (hold_off) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles with no beat accepted on either side
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("[obb2d_overlap_test_top] ERROR");
         $finish;
      end
   end

   function automatic logic [15:0] random_axis();
      case ($urandom_range(9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(32768)) - 16384);
      endcase
   endfunction

   // Unit-length axis from a table of quarter-turn, 3-4-5 and 45-degree angles
   function automatic void unit_axis(output logic [15:0] c, output logic [15:0] s);
      logic signed [15:0] u, v;
      case ($urandom_range(2))
         0: begin u = 16'sd16384; v = 16'sd0; end
         1: begin u = 16'sd9830; v = 16'sd13107; end
         default: begin u = 16'sd11585; v = 16'sd11585; end
      endcase
      if ($urandom_range(1)) begin c = u; s = v; end else begin c = v; s = u; end
      if ($urandom_range(1)) c = -c;
      if ($urandom_range(1)) s = -s;
   endfunction

   function automatic logic [31:0] random_coord(bit near);
      if (near) return 32'($signed($urandom_range(2 ** 22)) - 2 ** 21);
      return $urandom;
   endfunction

   function automatic logic [30:0] random_half(bit near);
      if (near) return 31'($urandom_range(2 ** 20));
      case ($urandom_range(3))
         0: return 31'h7FFF_FFFF;
         1: return 31'd0;
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_pair();
      req_payload_type p;
      bit near;
      near = $urandom_range(3) != 0;
      if (near) begin
         unit_axis(p.a_cos, p.a_sin);
         unit_axis(p.b_cos, p.b_sin);
      end else begin
         p.a_cos = random_axis(); p.a_sin = random_axis();
         p.b_cos = random_axis(); p.b_sin = random_axis();
      end
      p.a_center_x = random_coord(near); p.a_center_y = random_coord(near);
      p.b_center_x = random_coord(near); p.b_center_y = random_coord(near);
      p.a_half_len = random_half(near); p.a_half_wid = random_half(near);
      p.b_half_len = random_half(near); p.b_half_wid = random_half(near);
      return p;
   endfunction

   // Offer one beat, idling first at the current rate, and wait for acceptance
   task automatic send_pair(req_payload_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic req_payload_type axis_box(logic signed [31:0] bx, logic [30:0] h);
      req_payload_type p;
      p = '0;
      p.a_cos = 16'sd16384; p.b_cos = 16'sd16384;
      p.a_half_len = h; p.a_half_wid = h;
      p.b_half_len = h; p.b_half_wid = h;
      p.b_center_x = bx;
      return p;
   endfunction

   task automatic directed_pairs();
      req_payload_type p;
      // touching, just apart, just inside
      send_pair(axis_box(32'sh0002_0000, 31'h0001_0000));
      send_pair(axis_box(32'sh0002_0001, 31'h0001_0000));
      send_pair(axis_box(32'sh0001_FFFF, 31'h0001_0000));
      // extremes of centers and halves
      p = '0;
      p.a_center_x = 32'sh8000_0000; p.a_center_y = 32'sh8000_0000;
      p.b_center_x = 32'sh7FFF_FFFF; p.b_center_y = 32'sh7FFF_FFFF;
      p.a_cos = -16'sd16384; p.b_sin = 16'sd16384;
      p.a_half_len = '1; p.a_half_wid = '1; p.b_half_len = '1; p.b_half_wid = '1;
      send_pair(p);
      p.a_half_len = '0; p.a_half_wid = '0; p.b_half_len = '0; p.b_half_wid = '0;
      send_pair(p);
      // out-of-range and non-unit axes
      p.a_cos = 16'h8000; p.a_sin = 16'h7FFF; p.b_cos = 16'hFFFF; p.b_sin = 16'h8000;
      send_pair(p);
      p.a_cos = 16'h7FFF; p.a_sin = 16'h8000; p.b_cos = 16'h7FFF; p.b_sin = 16'h0001;
      p.a_half_len = '1; p.b_half_wid = '1;
      send_pair(p);
      p = '0;
      send_pair(p);
      // rotated: 45 degree box against axis-aligned box
      p = axis_box(32'sh0002_8000, 31'h0001_0000);
      p.b_cos = 16'sd11585; p.b_sin = 16'sd11585;
      send_pair(p);
      p.b_center_x = 32'sh0003_0000;
      send_pair(p);
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_pairs();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 13 : phase == 1 ? 88 : 0;
         recv_idle_pct = phase == 0 ? 88 : phase == 1 ? 13 : 0;
         for (int n = 0; n < 265; n++) begin
            if (phase == 2 && n == 20) begin
               hold_off = 1'b1;
               fork
                  begin
                     repeat (60) @(posedge clock);
                     hold_off = 1'b0;
                  end
               join_none
            end
            send_pair(random_pair());
         end
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_flags.size() != 0) @(posedge clock);
      repeat (StageCount + 4) @(posedge clock);
      if (board.error_count == 0)
         $display("[obb2d_overlap_test_top] OK");
      else
         $display("[obb2d_overlap_test_top] ERROR");
      $finish;
   end
endmodule
